>>> src/wavhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types and constants shared by the WAV header parser files.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  // Parse phases, one per header field or chunk region
  typedef enum logic [3:0] {
    PH_RIFF    = 4'd0,
    PH_RSIZE   = 4'd1,
    PH_WAVE    = 4'd2,
    PH_CID     = 4'd3,
    PH_CSIZE   = 4'd4,
    PH_AFMT    = 4'd5,
    PH_CHANS   = 4'd6,
    PH_RATE    = 4'd7,
    PH_BRATE   = 4'd8,
    PH_ALIGN   = 4'd9,
    PH_BITS    = 4'd10,
    PH_FMTSKIP = 4'd11,
    PH_SKIP    = 4'd12,
    PH_DONE    = 4'd13
  } phase_t;

  // Verdict codes
  typedef enum logic [2:0] {
    VD_OK         = 3'd0,
    VD_NOT_RIFF   = 3'd1,
    VD_NOT_WAVE   = 3'd2,
    VD_FMT_SHORT  = 3'd3,
    VD_BAD_FORMAT = 3'd4,
    VD_NO_FMT     = 3'd5
  } verdict_t;

  // Little-endian tags as 32-bit words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Minimum fmt chunk size and required field values
  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [31:0] PCM_FORMAT    = 32'd1;
  localparam logic [31:0] MONO_CHANS    = 32'd1;
  localparam logic [31:0] BLOCK_ALIGN   = 32'd2;
  localparam logic [31:0] BITS_PER_SMP  = 32'd16;

  // One parse step's result
  typedef struct packed {
    logic        valid;
    verdict_t    verdict;
    logic [31:0] sample_rate;
    logic [31:0] data_bytes;
  } wavhp_res_t;

endpackage

>>> src/wavhp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_in_if
// Byte stream channel into the WAV header parser.
// ----------------------------------------------------------------------------
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

>>> src/wavhp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_out_if
// Verdict channel out of the WAV header parser.
// ----------------------------------------------------------------------------
interface wavhp_out_if;
  import wavhp_pkg::*;

  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [31:0] sample_rate;
  logic [31:0] data_bytes;

  modport source (output valid, output verdict, output sample_rate, output data_bytes,
                  input ready);
  modport sink   (input valid, input verdict, input sample_rate, input data_bytes,
                  output ready);
endinterface

>>> src/wav_header_parser_core.sv
`timescale 1ns / 1ps
// A verdict on out_ch is registered: the byte that decides it passes the input register, then the output register.
// Throughput: one byte per cycle while the output register is free or being drained; state updates once per byte.
// A result waiting on out_ch does not stop the input register from holding the next byte.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to the RIFF tag.
// A byte with start_of_file set restarts parsing at any time.
// ----------------------------------------------------------------------------
// wav_header_parser_core
// Byte-serial RIFF/WAV header checker: input register, parse step, output register.
// ----------------------------------------------------------------------------
module wav_header_parser_core (
  input logic        clk,
  input logic        rst_n,
  wavhp_in_if.sink   in_ch,
  wavhp_out_if.source out_ch
);
  import wavhp_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_sof_r;

  // Output register
  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic [31:0] out_rate_r;
  logic [31:0] out_size_r;

  logic       proceed;
  logic       s1_fire;
  wavhp_res_t res;

  // Stage advances when the output register is free or being drained
  assign proceed     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && proceed;
  assign in_ch.ready = !s1_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.file_byte;
      s1_sof_r  <= in_ch.start_of_file;
    end
  end

  // Parse step
  wavhp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_fire),
    .file_byte     (s1_byte_r),
    .start_of_file (s1_sof_r),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed) begin
      out_valid_r <= s1_fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      out_verdict_r <= res.verdict;
      out_rate_r    <= res.sample_rate;
      out_size_r    <= res.data_bytes;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_verdict_r;
  assign out_ch.sample_rate = out_rate_r;
  assign out_ch.data_bytes  = out_size_r;

endmodule

>>> src/wavhp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_parser
// Header parse state and the per-byte update; result is combinational.
// ----------------------------------------------------------------------------
module wavhp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            file_byte,
  input  logic                  start_of_file,
  output wavhp_pkg::wavhp_res_t res
);
  import wavhp_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [1:0]  bw_r,      bw_nxt;
  logic [31:0] word_r,    word_nxt;
  logic [31:0] skip_r,    skip_nxt;
  logic [31:0] cid_r,     cid_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        fmt_ok_r,  fmt_ok_nxt;
  logic [31:0] rate_r,    rate_nxt;
  logic [31:0] brate_r,   brate_nxt;

  // Effective state: a start mark restarts from reset values
  phase_t      e_phase;
  logic [1:0]  e_bw;
  logic [31:0] e_word, e_skip, e_cid, e_rate, e_brate;
  logic        e_fmt_seen, e_fmt_ok;

  always_comb begin
    if (start_of_file) begin
      e_phase    = PH_RIFF;
      e_bw       = 2'd0;
      e_word     = '0;
      e_skip     = '0;
      e_cid      = '0;
      e_fmt_seen = 1'b0;
      e_fmt_ok   = 1'b1;
      e_rate     = '0;
      e_brate    = '0;
    end else begin
      e_phase    = phase_r;
      e_bw       = bw_r;
      e_word     = word_r;
      e_skip     = skip_r;
      e_cid      = cid_r;
      e_fmt_seen = fmt_seen_r;
      e_fmt_ok   = fmt_ok_r;
      e_rate     = rate_r;
      e_brate    = brate_r;
    end
  end

  // Shared datapath terms
  logic        need2, word_done, skip_zero, bits_ok, fmt_pass, skip_phase;
  logic [31:0] w_cur, skip_dec, want_brate;

  always_comb begin
    need2      = (e_phase == PH_AFMT) || (e_phase == PH_CHANS) ||
                 (e_phase == PH_ALIGN) || (e_phase == PH_BITS);
    skip_phase = (e_phase == PH_FMTSKIP) || (e_phase == PH_SKIP);
    w_cur      = ((e_bw == 2'd0) ? 32'd0 : e_word) | ({24'd0, file_byte} << {e_bw, 3'b000});
    word_done  = need2 ? (e_bw != 2'd0) : (e_bw == 2'd3);
    skip_dec   = e_skip - {31'd0, (e_skip != 32'd0)};
    skip_zero  = (skip_dec == 32'd0);
    // ((rate * 16) mod 2^32) / 8
    want_brate = {3'b000, e_rate[27:0], 1'b0};
    bits_ok    = e_fmt_ok && (w_cur == BITS_PER_SMP);
    fmt_pass   = ((e_phase == PH_BITS) ? bits_ok : e_fmt_ok) && (e_brate == want_brate);
  end

  // Next-state logic
  always_comb begin
    phase_nxt    = e_phase;
    bw_nxt       = e_bw;
    word_nxt     = e_word;
    skip_nxt     = e_skip;
    cid_nxt      = e_cid;
    fmt_seen_nxt = e_fmt_seen;
    fmt_ok_nxt   = e_fmt_ok;
    rate_nxt     = e_rate;
    brate_nxt    = e_brate;
    if (e_phase == PH_DONE) begin
      phase_nxt = PH_DONE;
    end else if (skip_phase) begin
      skip_nxt = skip_dec;
      if (skip_zero) begin
        if (e_phase == PH_FMTSKIP) begin
          phase_nxt = fmt_pass ? PH_CID : PH_DONE;
        end else begin
          phase_nxt = PH_CID;
        end
      end
    end else begin
      word_nxt = w_cur;
      bw_nxt   = word_done ? 2'd0 : e_bw + 2'd1;
      if (word_done) begin
        unique case (e_phase)
          PH_RIFF:  phase_nxt = (w_cur == TAG_RIFF) ? PH_RSIZE : PH_DONE;
          PH_RSIZE: phase_nxt = PH_WAVE;
          PH_WAVE:  phase_nxt = (w_cur == TAG_WAVE) ? PH_CID : PH_DONE;
          PH_CID: begin
            cid_nxt   = w_cur;
            phase_nxt = PH_CSIZE;
          end
          PH_CSIZE: begin
            if (e_cid == TAG_FMT) begin
              fmt_seen_nxt = 1'b1;
              if (w_cur < FMT_MIN_BYTES) begin
                phase_nxt = PH_DONE;
              end else begin
                skip_nxt   = w_cur - FMT_MIN_BYTES;
                fmt_ok_nxt = 1'b1;
                phase_nxt  = PH_AFMT;
              end
            end else if (e_cid == TAG_DATA) begin
              phase_nxt = PH_DONE;
            end else if (w_cur == 32'd0) begin
              phase_nxt = PH_CID;
            end else begin
              skip_nxt  = w_cur;
              phase_nxt = PH_SKIP;
            end
          end
          PH_AFMT: begin
            fmt_ok_nxt = e_fmt_ok && (w_cur == PCM_FORMAT);
            phase_nxt  = PH_CHANS;
          end
          PH_CHANS: begin
            fmt_ok_nxt = e_fmt_ok && (w_cur == MONO_CHANS);
            phase_nxt  = PH_RATE;
          end
          PH_RATE: begin
            rate_nxt  = w_cur;
            phase_nxt = PH_BRATE;
          end
          PH_BRATE: begin
            brate_nxt = w_cur;
            phase_nxt = PH_ALIGN;
          end
          PH_ALIGN: begin
            fmt_ok_nxt = e_fmt_ok && (w_cur == BLOCK_ALIGN);
            phase_nxt  = PH_BITS;
          end
          PH_BITS: begin
            fmt_ok_nxt = bits_ok;
            if (e_skip == 32'd0) begin
              phase_nxt = fmt_pass ? PH_CID : PH_DONE;
            end else begin
              phase_nxt = PH_FMTSKIP;
            end
          end
          default: phase_nxt = e_phase;
        endcase
      end
    end
  end

  // Result logic
  always_comb begin
    res = '{valid: 1'b0, verdict: VD_OK, sample_rate: 32'd0, data_bytes: 32'd0};
    if (e_phase == PH_DONE) begin
      res.valid = 1'b0;
    end else if (skip_phase) begin
      if (skip_zero && (e_phase == PH_FMTSKIP) && !fmt_pass) begin
        res.valid   = 1'b1;
        res.verdict = VD_BAD_FORMAT;
      end
    end else if (word_done) begin
      unique case (e_phase)
        PH_RIFF: begin
          res.valid   = (w_cur != TAG_RIFF);
          res.verdict = VD_NOT_RIFF;
        end
        PH_WAVE: begin
          res.valid   = (w_cur != TAG_WAVE);
          res.verdict = VD_NOT_WAVE;
        end
        PH_CSIZE: begin
          if (e_cid == TAG_FMT) begin
            res.valid   = (w_cur < FMT_MIN_BYTES);
            res.verdict = VD_FMT_SHORT;
          end else if (e_cid == TAG_DATA) begin
            res.valid = 1'b1;
            if (!e_fmt_seen) begin
              res.verdict = VD_NO_FMT;
            end else begin
              res.verdict     = VD_OK;
              res.sample_rate = e_rate;
              res.data_bytes  = w_cur;
            end
          end
        end
        PH_BITS: begin
          res.valid   = (e_skip == 32'd0) && !fmt_pass;
          res.verdict = VD_BAD_FORMAT;
        end
        default: res.valid = 1'b0;
      endcase
    end
  end

  // State registers, updated once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      bw_r       <= 2'd0;
      word_r     <= '0;
      skip_r     <= '0;
      cid_r      <= '0;
      fmt_seen_r <= 1'b0;
      fmt_ok_r   <= 1'b1;
      rate_r     <= '0;
      brate_r    <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bw_r       <= bw_nxt;
      word_r     <= word_nxt;
      skip_r     <= skip_nxt;
      cid_r      <= cid_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      fmt_ok_r   <= fmt_ok_nxt;
      rate_r     <= rate_nxt;
      brate_r    <= brate_nxt;
    end
  end

endmodule
